/* sv/smm_pkg.sv */
// Types and constants shared by the square matrix multiplier.
// Used by smm_cell and square_matrix_multiply; depends on nothing else.
package smm_pkg;

    localparam int unsigned IDX_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned SUM_W = 67;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned DIM_W = 4;

    localparam logic [1:0] KIND_A = 2'd0;
    localparam logic [1:0] KIND_B = 2'd1;
    localparam logic [1:0] KIND_C = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [DATA_W-1:0] product;
        logic                    last;
    } t_out;

    // element write broadcast to every cell
    typedef struct packed {
        logic                    a_en;
        logic                    b_en;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [DATA_W-1:0] value;
    } t_wr;

    // partial sum travelling down the chain
    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        i;
        logic [IDX_W-1:0]        j;
        logic                    last;
        logic signed [SUM_W-1:0] psum;
    } t_flow;

endpackage

/* sv/smm_cell.sv */
// One cell of the multiply-accumulate chain: holds column K of A and row K of B,
// adds A[i][K]*B[K][j] to the passing partial sum. Depends on smm_pkg.
module smm_cell #(
    parameter int MAX_DIM = 8,
    parameter int K = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [smm_pkg::IDX_W-1:0]    i_dm1,
    input  smm_pkg::t_wr                 i_wr,
    input  smm_pkg::t_flow               i_flow,
    output smm_pkg::t_flow               o_flow
);
    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic signed [smm_pkg::DATA_W-1:0] r_a [MAX_DIM];
    logic signed [smm_pkg::DATA_W-1:0] r_b [MAX_DIM];
    smm_pkg::t_flow                    r_mid;
    smm_pkg::t_flow                    r_flow;
    logic signed [smm_pkg::PROD_W-1:0] r_prod;
    logic                              r_use;

    always_ff @(posedge i_clk) begin
        if (i_wr.a_en && i_wr.col == smm_pkg::IDX_W'(K) && 32'(i_wr.row) < MAX_DIM) begin
            r_a[i_wr.row[AW-1:0]] <= i_wr.value;
        end
        if (i_wr.b_en && i_wr.row == smm_pkg::IDX_W'(K) && 32'(i_wr.col) < MAX_DIM) begin
            r_b[i_wr.col[AW-1:0]] <= i_wr.value;
        end
    end

    // stage 1: multiply, stage 2: accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.valid  <= 1'b0;
            r_flow.valid <= 1'b0;
        end else if (i_en) begin
            r_mid.valid  <= i_flow.valid;
            r_flow.valid <= r_mid.valid;
        end
        if (i_en) begin
            r_mid.i    <= i_flow.i;
            r_mid.j    <= i_flow.j;
            r_mid.last <= i_flow.last;
            r_mid.psum <= i_flow.psum;
            r_use      <= smm_pkg::IDX_W'(K) <= i_dm1;
            r_prod     <= r_a[i_flow.i[AW-1:0]] * r_b[i_flow.j[AW-1:0]];
            r_flow.i    <= r_mid.i;
            r_flow.j    <= r_mid.j;
            r_flow.last <= r_mid.last;
            // drop contributions from cells beyond the active size
            r_flow.psum <= r_mid.psum + (r_use ? smm_pkg::SUM_W'(r_prod)
                                               : smm_pkg::SUM_W'(0));
        end
    end

    assign o_flow = r_flow;

endmodule

/* sv/square_matrix_multiply.sv */
// Square matrix multiplier, signed Q16.16: sequencer, chain of MAC cells, output stage.
// Depends on smm_pkg and smm_cell.
//
// Input channel (i_valid/o_ready, i_data): kind A or B writes one element;
// kind C starts a product of the two matrices. Kind 3 and
// writes with out-of-range indices are dropped.
// Output channel (o_valid/i_ready, o_data): d*d elements of C in row-major
// order, the final one with last set. d is the dimension register, 0 read as
// 1 and clipped at MAX_DIM.
// One element enters the cell chain per cycle while the output is not
// stalled; each of the MAX_DIM cells has a multiply register and an add
// register, so an element passes from the source register through every
// cell's multiply and add registers and then the output register. No new
// item is taken until the last element has been transferred.
// A stall on the output freezes the whole chain; nothing is lost.
// Reset clears control state and sets the dimension to 8; matrix contents
// are undefined until written.
module square_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  smm_pkg::t_in                  i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output smm_pkg::t_out                 o_data,
    input  logic                          i_cfg_we,
    input  logic [smm_pkg::DIM_W-1:0]     i_cfg_wdata
);
    logic [smm_pkg::DIM_W-1:0] r_dim;
    logic [smm_pkg::IDX_W-1:0] r_dm1;
    logic [smm_pkg::IDX_W-1:0] r_i;
    logic [smm_pkg::IDX_W-1:0] r_j;
    logic                      r_busy;
    logic                      r_issuing;
    smm_pkg::t_flow            r_src;
    logic                      r_out_valid;
    smm_pkg::t_out             r_out;
    logic                      en;
    logic                      in_xfer;
    logic [smm_pkg::IDX_W-1:0] n_dm1;
    logic                      at_end;
    smm_pkg::t_wr              wr;
    smm_pkg::t_flow            flow [MAX_DIM+1];
    logic signed [smm_pkg::SUM_W-1:0] shifted;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = !r_busy;
    assign in_xfer = i_valid && o_ready;
    assign at_end  = (r_i == r_dm1) && (r_j == r_dm1);

    always_comb begin
        if (r_dim == '0) begin
            n_dm1 = '0;
        end else if (32'(r_dim) > MAX_DIM) begin
            n_dm1 = smm_pkg::IDX_W'(MAX_DIM - 1);
        end else begin
            n_dm1 = smm_pkg::IDX_W'(r_dim - 1'b1);
        end
    end

    always_comb begin
        wr.a_en  = in_xfer && i_data.kind == smm_pkg::KIND_A;
        wr.b_en  = in_xfer && i_data.kind == smm_pkg::KIND_B;
        wr.row   = i_data.row;
        wr.col   = i_data.col;
        wr.value = i_data.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= smm_pkg::DIM_W'(8);
        end else if (i_cfg_we) begin
            r_dim <= i_cfg_wdata;
        end
    end

    // sequencer: walk (i, j) one element per advancing cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_issuing   <= 1'b0;
            r_src.valid <= 1'b0;
        end else begin
            if (in_xfer && i_data.kind == smm_pkg::KIND_C) begin
                r_busy    <= 1'b1;
                r_issuing <= 1'b1;
                r_dm1     <= n_dm1;
                r_i       <= '0;
                r_j       <= '0;
            end else if (o_valid && i_ready && o_data.last) begin
                r_busy <= 1'b0;
            end
            if (en) begin
                r_src.valid <= r_issuing;
                r_src.i     <= r_i;
                r_src.j     <= r_j;
                r_src.last  <= at_end;
                r_src.psum  <= '0;
                if (r_issuing) begin
                    if (at_end) begin
                        r_issuing <= 1'b0;
                    end else if (r_j == r_dm1) begin
                        r_j <= '0;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
            end
        end
    end

    assign flow[0] = r_src;

    for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
        smm_cell #(
            .MAX_DIM (MAX_DIM),
            .K       (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_dm1   (r_dm1),
            .i_wr    (wr),
            .i_flow  (flow[k]),
            .o_flow  (flow[k+1])
        );
    end

    assign shifted = flow[MAX_DIM].psum >>> smm_pkg::FRAC_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= flow[MAX_DIM].valid;
        end
    end

    // floor shift, then saturate to 32 bits
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.out_row <= flow[MAX_DIM].i;
            r_out.out_col <= flow[MAX_DIM].j;
            r_out.last    <= flow[MAX_DIM].last;
            if (shifted > smm_pkg::SUM_W'(signed'(32'sh7FFFFFFF))) begin
                r_out.product <= 32'sh7FFFFFFF;
            end else if (shifted < smm_pkg::SUM_W'(signed'(-33'sh80000000))) begin
                r_out.product <= -32'sh80000000;
            end else begin
                r_out.product <= shifted[smm_pkg::DATA_W-1:0];
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
